// ===== sv/r2h_pkg.sv =====
// Shared constants and types for the RGB to HSV converter.
// Depends on nothing; imported by the converter and its checker.
package r2h_pkg;

  localparam int CHANNEL_BITS_DEF = 8;

  // Hue is in 1/64 degree: one 60 degree sector is 3840 units
  localparam int HUE_W            = 15;
  localparam int HUE_QBITS        = 12;
  localparam int HUE_SECTOR_SCALE = 3840;
  localparam int HUE_FULL_CIRCLE  = 23040;
  localparam int HUE_BASE_GREEN   = 2 * HUE_SECTOR_SCALE;
  localparam int HUE_BASE_BLUE    = 4 * HUE_SECTOR_SCALE;

  // Channel that holds the maximum
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

endpackage

// ===== sv/r2h_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Stage advance comes from the parent; depends on no package.
module r2h_divider #(
  parameter int DEN_W = 8,
  parameter int QBITS = 12
) (
  input  logic                   clk,
  input  logic [QBITS-1:0]       adv,
  input  logic [DEN_W+QBITS-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic [QBITS-1:0]       quot,
  output logic                   rem_nz
);

  localparam int W = DEN_W + QBITS;

  typedef logic [W:0] ext_t;

  logic [W-1:0]     rem [QBITS];
  logic [QBITS-1:0] quo [QBITS];
  logic [DEN_W-1:0] dvs [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    localparam int SH = QBITS - 1 - k;

    logic [W-1:0]     rem_prev;
    logic [QBITS-1:0] quo_prev;
    logic [DEN_W-1:0] dvs_prev;
    logic [W:0]       trial;

    if (k == 0) begin : g_first
      assign rem_prev = num;
      assign quo_prev = '0;
      assign dvs_prev = den;
    end else begin : g_next
      assign rem_prev = rem[k-1];
      assign quo_prev = quo[k-1];
      assign dvs_prev = dvs[k-1];
    end

    // Subtract the shifted divisor; keep the old remainder if it goes negative
    assign trial = {1'b0, rem_prev} - (ext_t'(dvs_prev) << SH);

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem[k] <= trial[W] ? rem_prev : trial[W-1:0];
        quo[k] <= {quo_prev[QBITS-2:0], ~trial[W]};
        dvs[k] <= dvs_prev;
      end
    end
  end

  assign quot   = quo[QBITS-1];
  assign rem_nz = |rem[QBITS-1];

endmodule

// ===== sv/rgb_to_hsv_converter.sv =====
// RGB to HSV converter. Throughput is one pixel per clock while out_stall
// is low; the depth is set by the two pipelined dividers, which resolve
// one quotient bit per stage. Empty stages collapse under out_stall.
// rst clears all stage valid bits; data registers keep.
// Depends on r2h_pkg and r2h_divider.
module rgb_to_hsv_converter import r2h_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CHANNEL_BITS-1:0] red_in,
  input  logic [CHANNEL_BITS-1:0] green_in,
  input  logic [CHANNEL_BITS-1:0] blue_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [HUE_W-1:0]        hue_out,
  output logic [CHANNEL_BITS-1:0] sat_out,
  output logic [CHANNEL_BITS-1:0] val_out
);

  localparam int N    = CHANNEL_BITS;
  localparam int QB   = (N > HUE_QBITS) ? N : HUE_QBITS;
  localparam int W    = N + QB;
  localparam int S    = QB + 4;
  localparam int LAST = S - 1;

  typedef struct packed {
    logic [N-1:0] mx;
    sector_t      sector;
    logic         neg;
    logic         gray;
  } side_t;

  // ---------------- stage valid bits and advance ----------------
  logic [S-1:0] vld;
  logic [S:0]   adv;

  always_comb begin
    adv[S] = ~out_stall;
    for (int k = S - 1; k >= 0; k--) begin
      adv[k] = ~vld[k] | adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < S; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_stall  = ~adv[0];
  assign out_valid = vld[LAST];

  // ---------------- stage A: max, min, sector, channel difference ----------------
  logic         red_top, green_top;
  logic [N-1:0] mx_next, mn_next, dabs_next;
  logic         neg_next;
  sector_t      sector_next;

  assign red_top   = (red_in >= green_in) && (red_in >= blue_in);
  assign green_top = (green_in >= blue_in);

  always_comb begin
    if (red_top) begin
      sector_next = SECT_RED;
      mx_next     = red_in;
      neg_next    = green_in < blue_in;
      dabs_next   = neg_next ? blue_in - green_in : green_in - blue_in;
    end else if (green_top) begin
      sector_next = SECT_GREEN;
      mx_next     = green_in;
      neg_next    = blue_in < red_in;
      dabs_next   = neg_next ? red_in - blue_in : blue_in - red_in;
    end else begin
      sector_next = SECT_BLUE;
      mx_next     = blue_in;
      neg_next    = red_in < green_in;
      dabs_next   = neg_next ? green_in - red_in : red_in - green_in;
    end
    if (red_in <= green_in) begin
      mn_next = (red_in <= blue_in) ? red_in : blue_in;
    end else begin
      mn_next = (green_in <= blue_in) ? green_in : blue_in;
    end
  end

  logic [N-1:0] a_mx, a_mn, a_dabs;
  logic         a_neg;
  sector_t      a_sector;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a_mx     <= mx_next;
      a_mn     <= mn_next;
      a_dabs   <= dabs_next;
      a_neg    <= neg_next;
      a_sector <= sector_next;
    end
  end

  // ---------------- stage B: delta and hue dividend ----------------
  side_t        b_side;
  logic [N-1:0] b_delta;
  logic [W-1:0] b_hnum;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      b_side.mx     <= a_mx;
      b_side.sector <= a_sector;
      b_side.neg    <= a_neg;
      b_side.gray   <= (a_mx == a_mn);
      b_delta       <= a_mx - a_mn;
      b_hnum        <= W'(a_dabs) * W'(HUE_SECTOR_SCALE);
    end
  end

  // ---------------- stage C: saturation dividend ----------------
  side_t        c_side;
  logic [N-1:0] c_delta;
  logic [W-1:0] c_hnum, c_snum;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      c_side  <= b_side;
      c_delta <= b_delta;
      c_hnum  <= b_hnum;
      // full scale times delta, full scale being all ones
      c_snum  <= (W'(b_delta) << N) - W'(b_delta);
    end
  end

  // ---------------- divider stages ----------------
  logic [QB-1:0] hue_q, sat_q;
  logic          hue_rnz;
  side_t         d_side [QB];

  r2h_divider #(
    .DEN_W (N),
    .QBITS (QB)
  ) u_hue_div (
    .clk    (clk),
    .adv    (adv[QB+2:3]),
    .num    (c_hnum),
    .den    (c_delta),
    .quot   (hue_q),
    .rem_nz (hue_rnz)
  );

  r2h_divider #(
    .DEN_W (N),
    .QBITS (QB)
  ) u_sat_div (
    .clk    (clk),
    .adv    (adv[QB+2:3]),
    .num    (c_snum),
    .den    (c_side.mx),
    .quot   (sat_q),
    .rem_nz ()
  );

  // carry the side data alongside the divider stages
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d_side[0] <= c_side;
    end
    for (int k = 1; k < QB; k++) begin
      if (adv[k+3]) begin
        d_side[k] <= d_side[k-1];
      end
    end
  end

  // ---------------- final stage: assemble hue, output register ----------------
  side_t        f_side;
  logic [15:0]  hue_base, hue_calc;
  logic [HUE_W-1:0] hue_next;
  logic [N-1:0] sat_next;

  assign f_side = d_side[QB-1];

  always_comb begin
    case (f_side.sector)
      SECT_RED:   hue_base = f_side.neg ? 16'(HUE_FULL_CIRCLE) : '0;
      SECT_GREEN: hue_base = 16'(HUE_BASE_GREEN);
      SECT_BLUE:  hue_base = 16'(HUE_BASE_BLUE);
      default:    hue_base = '0;
    endcase
    // negative difference: floor of a negative quotient rounds away from zero
    if (f_side.neg) begin
      hue_calc = hue_base - 16'(hue_q) - 16'(hue_rnz);
    end else begin
      hue_calc = hue_base + 16'(hue_q);
    end
    hue_next = f_side.gray ? '0 : hue_calc[HUE_W-1:0];
    sat_next = (f_side.mx == '0) ? '0 : sat_q[N-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      hue_out <= hue_next;
      sat_out <= sat_next;
      val_out <= f_side.mx;
    end
  end

endmodule

// ===== sv/r2h_checker.sv =====
// Port-level checks for the RGB to HSV converter, bound to its top level.
// Depends on r2h_pkg.
module r2h_checker import r2h_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [HUE_W-1:0]        hue_out,
  input logic [CHANNEL_BITS-1:0] sat_out,
  input logic [CHANNEL_BITS-1:0] val_out
);

  localparam int HUE_WIDTH_LIMIT = HUE_FULL_CIRCLE;

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue_out < HUE_WIDTH_LIMIT))
    else $error("hue out of range");

  // zero saturation only for a grey pixel, which carries zero hue
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sat_out == '0) |-> (hue_out == '0))
    else $error("zero saturation with nonzero hue");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hue_out) && $stable(sat_out)
                                  && $stable(val_out)))
    else $error("stalled transaction changed");

  // input stalls only when the output is held off
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("in_stall high without out_stall");

endmodule

bind rgb_to_hsv_converter r2h_checker #(
  .CHANNEL_BITS (CHANNEL_BITS)
) u_r2h_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hue_out   (hue_out),
  .sat_out   (sat_out),
  .val_out   (val_out)
);
